### hdl/teq_pkg.sv
package teq_pkg;

  localparam int TIME_W      = 32;
  localparam int TASK_W      = 8;
  localparam int DELAY_W     = 20;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    RES_RELEASED = 2'd0,
    RES_ACCEPTED = 2'd1,
    RES_DROPPED  = 2'd2
  } result_kind_e;

  // best due entry seen so far along the chain
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] expiry;
    logic [TASK_W-1:0] task_id;
  } teq_tok_t;

  typedef struct packed {
    logic active;
    logic load;
    logic shift;
  } teq_cell_ctrl_t;

endpackage

### hdl/teq_intf.sv
interface teq_req_if;
  import teq_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [TASK_W-1:0]  task_id;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, kind, task_id, delay_ms, input ready);
  modport sink (input valid, kind, task_id, delay_ms, output ready);
endinterface

interface teq_res_if;
  import teq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [TASK_W-1:0] task_id_res;
  logic [TIME_W-1:0] expire_time;
  logic              last;

  modport source (output valid, result_kind, task_id_res, expire_time, last, input ready);
  modport sink (input valid, result_kind, task_id_res, expire_time, last, output ready);
endinterface

### hdl/teq_cell.sv
module teq_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [teq_pkg::TIME_W-1:0]   time_now_i,
  input  teq_pkg::teq_cell_ctrl_t      ctrl_i,
  input  logic [teq_pkg::TIME_W-1:0]   load_expiry_i,
  input  logic [teq_pkg::TASK_W-1:0]   load_task_i,
  input  logic [teq_pkg::TIME_W-1:0]   next_expiry_i,
  input  logic [teq_pkg::TASK_W-1:0]   next_task_i,
  input  teq_pkg::teq_tok_t            tok_i,
  input  logic [IDX_W-1:0]             tok_idx_i,
  output teq_pkg::teq_tok_t            tok_o,
  output logic [IDX_W-1:0]             tok_idx_o,
  output logic [teq_pkg::TIME_W-1:0]   expiry_o,
  output logic [teq_pkg::TASK_W-1:0]   task_o
);
  import teq_pkg::*;

  logic [TIME_W-1:0] expiry_q;
  logic [TASK_W-1:0] task_q;
  teq_tok_t          tok_q;
  logic [IDX_W-1:0]  tok_idx_q;
  logic [TIME_W-1:0] diff;
  logic              due;
  logic              take;

  assign diff = time_now_i - expiry_q;
  assign due  = ctrl_i.active && (diff != '0) && !diff[TIME_W-1];
  // strict compare keeps the earlier cell on equal expiry
  assign take = due && (!tok_i.found || (diff > tok_i.diff));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      expiry_q <= load_expiry_i;
      task_q   <= load_task_i;
    end else if (ctrl_i.shift) begin
      expiry_q <= next_expiry_i;
      task_q   <= next_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.found <= 1'b0;
    end else if (take) begin
      tok_q.found   <= 1'b1;
      tok_q.diff    <= diff;
      tok_q.expiry  <= expiry_q;
      tok_q.task_id <= task_q;
      tok_idx_q     <= IDX_W'(CELL_IDX);
    end else begin
      tok_q     <= tok_i;
      tok_idx_q <= tok_idx_i;
    end
  end

  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;
  assign expiry_o  = expiry_q;
  assign task_o    = task_q;

endmodule

### hdl/timer_expiry_queue.sv
// a sleep word's result is registered in the output register in the cycle after acceptance
// a tick runs one search per release plus a last search that releases nothing (no due task left,
// or MAX_RESULTS reached): the best-so-far word crosses the cell chain, one cell per cycle
// a tick keeps ready low from acceptance until its last search is decided and the state is idle again
// throughput: one sleep word per cycle while results are taken and no tick is being processed
// reset: asynchronous active low, clears time, occupancy and all control; no clearing pass
module timer_expiry_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  teq_req_if.sink   req_i,
  teq_res_if.source res_o
);
  import teq_pkg::*;

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OccW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE
  } state_e;

  state_e             state_q;
  logic [TIME_W-1:0]  time_now_q;
  logic [OccW-1:0]    occ_q;
  logic [IdxW-1:0]    cnt_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic               pend_q;
  logic [TASK_W-1:0]  pend_task_q;
  logic [TIME_W-1:0]  pend_expiry_q;
  logic               res_valid_q;
  result_kind_e       res_kind_q;
  logic [TASK_W-1:0]  res_task_q;
  logic [TIME_W-1:0]  res_expiry_q;
  logic               res_last_q;

  teq_tok_t           tok [QUEUE_DEPTH+1];
  logic [IdxW-1:0]    tok_idx [QUEUE_DEPTH+1];
  logic [TIME_W-1:0]  cell_expiry [QUEUE_DEPTH];
  logic [TASK_W-1:0]  cell_task [QUEUE_DEPTH];
  teq_cell_ctrl_t     cell_ctrl [QUEUE_DEPTH];

  logic               out_free;
  logic               req_acc;
  logic               sleep_acc;
  logic               tick_acc;
  logic               has_room;
  logic               append;
  logic [TIME_W-1:0]  sleep_expiry;
  teq_tok_t           tail;
  logic [IdxW-1:0]    rem_idx;
  logic               take;
  logic               decide_go;
  logic               remove;
  logic               res_load;

  assign out_free     = !res_valid_q || res_o.ready;
  assign req_i.ready  = (state_q == ST_IDLE) && out_free;
  assign req_acc      = req_i.valid && req_i.ready;
  assign sleep_acc    = req_acc && (req_i.kind == KIND_SLEEP);
  assign tick_acc     = req_acc && (req_i.kind == KIND_TICK);
  assign has_room     = (occ_q != OccW'(QUEUE_DEPTH));
  assign append       = sleep_acc && has_room;
  assign sleep_expiry = time_now_q + {{(TIME_W-DELAY_W){1'b0}}, req_i.delay_ms};

  assign tok[0]     = '0;
  assign tok_idx[0] = '0;
  assign tail       = tok[QUEUE_DEPTH];
  assign rem_idx    = tok_idx[QUEUE_DEPTH];
  assign take       = tail.found && (res_cnt_q != RES_CNT_W'(MAX_RESULTS));
  assign decide_go  = (state_q == ST_DECIDE) && (!pend_q || out_free);
  assign remove     = decide_go && take;
  assign res_load   = sleep_acc || (decide_go && pend_q);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [TIME_W-1:0] next_expiry;
    logic [TASK_W-1:0] next_task;

    if (g < QUEUE_DEPTH - 1) begin : g_mid
      assign next_expiry = cell_expiry[g+1];
      assign next_task   = cell_task[g+1];
    end else begin : g_end
      assign next_expiry = cell_expiry[g];
      assign next_task   = cell_task[g];
    end

    assign cell_ctrl[g].active = (OccW'(g) < occ_q);
    assign cell_ctrl[g].load   = append && (occ_q == OccW'(g));
    assign cell_ctrl[g].shift  = remove && (IdxW'(g) >= rem_idx);

    teq_cell #(
      .IDX_W    (IdxW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .time_now_i    (time_now_q),
      .ctrl_i        (cell_ctrl[g]),
      .load_expiry_i (sleep_expiry),
      .load_task_i   (req_i.task_id),
      .next_expiry_i (next_expiry),
      .next_task_i   (next_task),
      .tok_i         (tok[g]),
      .tok_idx_i     (tok_idx[g]),
      .tok_o         (tok[g+1]),
      .tok_idx_o     (tok_idx[g+1]),
      .expiry_o      (cell_expiry[g]),
      .task_o        (cell_task[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_now_q  <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      res_cnt_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (!res_load && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (sleep_acc) begin
            res_valid_q  <= 1'b1;
            res_kind_q   <= has_room ? RES_ACCEPTED : RES_DROPPED;
            res_task_q   <= req_i.task_id;
            res_expiry_q <= sleep_expiry;
            res_last_q   <= 1'b1;
            if (has_room) begin
              occ_q <= occ_q + OccW'(1);
            end
          end else if (tick_acc) begin
            time_now_q <= time_now_q + TIME_W'(1);
            cnt_q      <= '0;
            res_cnt_q  <= '0;
            pend_q     <= 1'b0;
            state_q    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (cnt_q == IdxW'(QUEUE_DEPTH - 1)) begin
            state_q <= ST_DECIDE;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        ST_DECIDE: begin
          if (decide_go) begin
            // previous release goes out once we know whether another follows
            if (pend_q) begin
              res_valid_q  <= 1'b1;
              res_kind_q   <= RES_RELEASED;
              res_task_q   <= pend_task_q;
              res_expiry_q <= pend_expiry_q;
              res_last_q   <= !take;
            end
            if (take) begin
              pend_q        <= 1'b1;
              pend_task_q   <= tail.task_id;
              pend_expiry_q <= tail.expiry;
              occ_q         <= occ_q - OccW'(1);
              res_cnt_q     <= res_cnt_q + RES_CNT_W'(1);
              cnt_q         <= '0;
              state_q       <= ST_SEARCH;
            end else begin
              pend_q  <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.result_kind = res_kind_q;
  assign res_o.task_id_res = res_task_q;
  assign res_o.expire_time = res_expiry_q;
  assign res_o.last        = res_last_q;

endmodule

### hdl/teq_checker.sv
module teq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       req_kind_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [1:0]                 res_kind_i,
  input logic [teq_pkg::TASK_W-1:0] res_task_i,
  input logic [teq_pkg::TIME_W-1:0] res_expiry_i,
  input logic                       res_last_i
);
  import teq_pkg::*;

  logic sleep_acc;
  logic tick_acc;

  assign sleep_acc = req_valid_i && req_ready_i && (req_kind_i == KIND_SLEEP);
  assign tick_acc  = req_valid_i && req_ready_i && (req_kind_i == KIND_TICK);

  // sleep answer lands in the next cycle and closes its word group
  a_sleep_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sleep_acc |=> res_valid_i && res_last_i && (res_kind_i != RES_RELEASED))
    else $error("sleep word not answered in next cycle");

  // a tick starts a search: no new word and no result right after
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !req_ready_i && !res_valid_i)
    else $error("tick did not start a search");

  a_single_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i != RES_RELEASED) |-> res_last_i)
    else $error("sleep answer without last");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_kind_i == RES_RELEASED) || (res_kind_i == RES_ACCEPTED) ||
                    (res_kind_i == RES_DROPPED))
    else $error("illegal result kind");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i) &&
      $stable(res_task_i) && $stable(res_expiry_i) && $stable(res_last_i))
    else $error("stalled result changed");

endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_kind_i   (req_i.kind),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.result_kind),
  .res_task_i   (res_o.task_id_res),
  .res_expiry_i (res_o.expire_time),
  .res_last_i   (res_o.last)
);
